@@ design/tlpq_pkg.sv @@
package tlpq_pkg;

  // result codes of one step
  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_DROPPED    = 3'd1,
    ST_FROM_HIGH  = 3'd2,
    ST_FROM_LOW   = 3'd3,
    ST_BOTH_EMPTY = 3'd4
  } tlpq_status_e;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } tlpq_action_e;

  typedef enum logic {
    PRIO_HIGH = 1'b0,
    PRIO_LOW  = 1'b1
  } tlpq_prio_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_RESP = 3'b100
  } tlpq_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;   // input beat accepted, execute it now
    logic grab;   // load read data into the result register
  } tlpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_pending;  // current input beat pops an entry
  } tlpq_stat_t;

endpackage

@@ design/tlpq_in_if.sv @@
interface tlpq_in_if #(
  parameter int unsigned DataWidth = 16
) ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic                 priority_req;
  logic [DataWidth-1:0] payload;

  modport source (output valid, output action, output priority_req, output payload,
                  input ready);
  modport sink   (input valid, input action, input priority_req, input payload,
                  output ready);
endinterface

@@ design/tlpq_out_if.sv @@
interface tlpq_out_if #(
  parameter int unsigned DataWidth  = 16,
  parameter int unsigned LevelWidth = 6
) ();
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [DataWidth-1:0]  item_out;
  logic [LevelWidth-1:0] high_level;
  logic [LevelWidth-1:0] low_level;

  modport source (output valid, output status, output item_out, output high_level,
                  output low_level, input ready);
  modport sink   (input valid, input status, input item_out, input high_level,
                  input low_level, output ready);
endinterface

@@ design/tlpq_fifo.sv @@
module tlpq_fifo #(
  parameter int unsigned Depth     = 32,
  parameter int unsigned DataWidth = 16,
  parameter int unsigned AddrWidth = $clog2(Depth),
  parameter int unsigned CntWidth  = $clog2(Depth + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 pop_i,
  input  logic [DataWidth-1:0] wdata_i,
  output logic [DataWidth-1:0] rdata_o,
  output logic [CntWidth-1:0]  fill_o,
  output logic                 full_o,
  output logic                 empty_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;
  logic [AddrWidth-1:0] head_q, head_d;
  logic [AddrWidth-1:0] tail_q, tail_d;
  logic [CntWidth-1:0]  fill_q, fill_d;

  assign full_o  = (fill_q == CntWidth'(Depth));
  assign empty_o = (fill_q == '0);
  assign fill_o  = fill_q;
  assign rdata_o = rdata_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (push_i) begin
      tail_d = (tail_q == AddrWidth'(Depth - 1)) ? '0 : tail_q + 1'b1;
      fill_d = fill_q + 1'b1;
    end else if (pop_i) begin
      head_d = (head_q == AddrWidth'(Depth - 1)) ? '0 : head_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= wdata_i;
    end
    if (pop_i) begin
      rdata_q <= mem_q[head_q];
    end
  end

endmodule

@@ design/tlpq_datapath.sv @@
module tlpq_datapath import tlpq_pkg::*; #(
  parameter int unsigned Depth     = 32,
  parameter int unsigned DataWidth = 16,
  parameter int unsigned CntWidth  = $clog2(Depth + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlpq_cmd_t            cmd_i,
  output tlpq_stat_t           stat_o,
  input  logic                 action_i,
  input  logic                 priority_req_i,
  input  logic [DataWidth-1:0] payload_i,
  output logic [2:0]           status_o,
  output logic [DataWidth-1:0] item_o,
  output logic [CntWidth-1:0]  high_level_o,
  output logic [CntWidth-1:0]  low_level_o
);

  logic                 hi_push, hi_pop, hi_full, hi_empty;
  logic                 lo_push, lo_pop, lo_full, lo_empty;
  logic [DataWidth-1:0] hi_rdata, lo_rdata;
  logic                 is_deq, to_low, tgt_full;
  tlpq_status_e         status_d, status_q;
  logic                 sel_low_q;
  logic [DataWidth-1:0] item_q;

  assign is_deq   = (tlpq_action_e'(action_i) == ACT_DEQUEUE);
  assign to_low   = (tlpq_prio_e'(priority_req_i) == PRIO_LOW);
  assign tgt_full = to_low ? lo_full : hi_full;

  // strict priority: high queue drains first
  assign hi_push = cmd_i.take && !is_deq && !to_low && !hi_full;
  assign lo_push = cmd_i.take && !is_deq &&  to_low && !lo_full;
  assign hi_pop  = cmd_i.take &&  is_deq && !hi_empty;
  assign lo_pop  = cmd_i.take &&  is_deq &&  hi_empty && !lo_empty;

  assign stat_o.pop_pending = is_deq && !(hi_empty && lo_empty);

  always_comb begin
    priority if (!is_deq) begin
      status_d = tgt_full ? ST_DROPPED : ST_STORED;
    end else if (!hi_empty) begin
      status_d = ST_FROM_HIGH;
    end else if (!lo_empty) begin
      status_d = ST_FROM_LOW;
    end else begin
      status_d = ST_BOTH_EMPTY;
    end
  end

  tlpq_fifo #(
    .Depth     (Depth),
    .DataWidth (DataWidth)
  ) u_high (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (hi_push),
    .pop_i   (hi_pop),
    .wdata_i (payload_i),
    .rdata_o (hi_rdata),
    .fill_o  (high_level_o),
    .full_o  (hi_full),
    .empty_o (hi_empty)
  );

  tlpq_fifo #(
    .Depth     (Depth),
    .DataWidth (DataWidth)
  ) u_low (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (lo_push),
    .pop_i   (lo_pop),
    .wdata_i (payload_i),
    .rdata_o (lo_rdata),
    .fill_o  (low_level_o),
    .full_o  (lo_full),
    .empty_o (lo_empty)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      status_q  <= status_d;
      sel_low_q <= lo_pop;
      item_q    <= '0;
    end else if (cmd_i.grab) begin
      item_q <= sel_low_q ? lo_rdata : hi_rdata;
    end
  end

  assign status_o = status_q;
  assign item_o   = item_q;

endmodule

@@ design/tlpq_ctrl.sv @@
module tlpq_ctrl import tlpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  tlpq_stat_t stat_i,
  output tlpq_cmd_t  cmd_o
);

  tlpq_state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign cmd_o.take  = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.grab  = (state_q == S_READ);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // a pop passes through S_READ for the registered memory read
          state_d = stat_i.pop_pending ? S_READ : S_RESP;
        end
      end
      S_READ: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/two_level_priority_queue_top.sv @@
// strict priority scheduler over two circular queues (high and low)
// req_i: one beat is one command. action 0 enqueues payload into the queue
//   named by priority_req (0 high, 1 low), action 1 dequeues, high first.
// rsp_o: exactly one beat per command with status (0 stored, 1 dropped as
//   full, 2 from high, 3 from low, 4 both empty), item_out (dequeued value,
//   else zero) and both queue levels after the command.
// one command is in flight at a time; req_i.ready is high only while idle.
// after accept an enqueue or an empty dequeue goes straight to S_RESP, while a
//   dequeue that pops passes through S_READ first, set by the registered read
//   port of the queue memory.
// while the receiver stalls the response is held in its output register and
//   no new command is taken.
// reset clears the controller and the head, tail and fill counters of both
//   queues; the queue memories are not cleared and need no clearing pass.
module two_level_priority_queue_top import tlpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned DATA_WIDTH  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tlpq_in_if.sink      req_i,
  tlpq_out_if.source   rsp_o
);

  localparam int unsigned LevelWidth = $clog2(QUEUE_DEPTH + 1);

  tlpq_cmd_t             cmd;
  tlpq_stat_t            stat;
  logic [LevelWidth-1:0] high_level, low_level;

  tlpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tlpq_datapath #(
    .Depth     (QUEUE_DEPTH),
    .DataWidth (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (req_i.action),
    .priority_req_i (req_i.priority_req),
    .payload_i      (req_i.payload),
    .status_o       (rsp_o.status),
    .item_o         (rsp_o.item_out),
    .high_level_o   (high_level),
    .low_level_o    (low_level)
  );

  assign rsp_o.high_level = high_level;
  assign rsp_o.low_level  = low_level;

  // sequential block: never takes a command while a response is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("command accepted while response pending");

  // levels move only as a result of an accepted command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.valid && req_i.ready) |=> ($stable(high_level) && $stable(low_level)))
    else $error("queue level changed without a command");

  // a dequeue with entries in the high queue is served from it after S_READ
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.action && (high_level != '0)) |->
      ##2 (rsp_o.valid && (rsp_o.status == ST_FROM_HIGH)))
    else $error("strict priority dequeue not served from high queue");

  // levels never exceed the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (high_level <= LevelWidth'(QUEUE_DEPTH)) && (low_level <= LevelWidth'(QUEUE_DEPTH)))
    else $error("queue level beyond depth");

endmodule
